FILE: design/servo_short_packet_framer_unit_defines.svh
// assertion macros shared by the servo short packet framer rtl
// depends on nothing; included by the modules that carry assertions
`ifndef SERVO_SHORT_PACKET_FRAMER_UNIT_DEFINES_SVH
`define SERVO_SHORT_PACKET_FRAMER_UNIT_DEFINES_SVH

// condition a implies condition b in the same cycle, outside reset
`define SSPF_ASSERT_SAME(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error(msg);

// condition a implies condition b in the next cycle, outside reset
`define SSPF_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error(msg);

`endif

FILE: design/sspf_pkg.sv
// shared types and constants for the servo short packet framer
// depends on nothing
package sspf_pkg;

    // command codes
    typedef enum logic [1:0] {
        OP_TORQUE    = 2'd0,
        OP_GOAL      = 2'd1,
        OP_GOAL_TIME = 2'd2
    } op_t;

    // code with no command; such a transfer produces no packet
    localparam logic [1:0] OP_CODE_UNDEF = 2'd3;

    // packet bytes
    localparam logic [7:0] HDR0_BYTE   = 8'hFA;
    localparam logic [7:0] HDR1_BYTE   = 8'hAF;
    localparam logic [7:0] FLAGS_BYTE  = 8'h00;
    localparam logic [7:0] ADDR_TORQUE = 8'h24;
    localparam logic [7:0] ADDR_GOAL   = 8'h1E;
    localparam logic [7:0] LEN_TORQUE  = 8'h01;
    localparam logic [7:0] LEN_GOAL    = 8'h02;
    localparam logic [7:0] LEN_TIME    = 8'h04;
    localparam logic [7:0] COUNT_BYTE  = 8'h01;

    // byte index within a packet
    localparam int IDX_W = 4;
    typedef logic [IDX_W-1:0] idx_t;

    // byte positions
    localparam idx_t IDX_HDR0  = 4'd0;
    localparam idx_t IDX_HDR1  = 4'd1;
    localparam idx_t IDX_ID    = 4'd2;
    localparam idx_t IDX_FLAGS = 4'd3;
    localparam idx_t IDX_ADDR  = 4'd4;
    localparam idx_t IDX_LEN   = 4'd5;
    localparam idx_t IDX_COUNT = 4'd6;
    localparam idx_t IDX_D0    = 4'd7;
    localparam idx_t IDX_D1    = 4'd8;
    localparam idx_t IDX_D2    = 4'd9;
    localparam idx_t IDX_D3    = 4'd10;
    localparam idx_t IDX_D4    = 4'd11;

    // index of the checksum byte, which ends the packet
    localparam idx_t LAST_TORQUE = 4'd8;
    localparam idx_t LAST_GOAL   = 4'd9;
    localparam idx_t LAST_TIME   = 4'd11;

endpackage

FILE: design/servo_short_packet_framer_unit.sv
// servo short packet framer: one defined command in, one packet out byte by byte
// depends on sspf_pkg and servo_short_packet_framer_unit_defines.svh
// The command is captured in the packet register; its bytes then pass through the output register.
// Throughput: one byte per cycle while the receiver is ready; a packet holds 9, 10 or 12 bytes by command,
//   and the next command is taken in the cycle its predecessor's checksum byte leaves
//   the byte selector, so packets follow without gaps.
// Reset: aresetn (synchronous, active low) empties the packet and output registers.
`include "servo_short_packet_framer_unit_defines.svh"

module servo_short_packet_framer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], servo_id[9:2], value[25:10], move_time[41:26]
    // packet byte channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte[7:0]
    output logic        m_tlast    // last_byte
);

    // command fields
    logic [1:0]  s_op;
    logic [7:0]  s_servo_id;
    logic [15:0] s_value;
    logic [15:0] s_move_time;

    assign s_op        = s_tdata[1:0];
    assign s_servo_id  = s_tdata[9:2];
    assign s_value     = s_tdata[25:10];
    assign s_move_time = s_tdata[41:26];

    // packet register
    logic                pkt_valid_reg, pkt_valid_next;
    sspf_pkg::op_t       op_reg;
    logic [7:0]          id_reg;
    logic [15:0]         value_reg;
    logic [15:0]         time_reg;
    logic [7:0]          sum_reg;
    sspf_pkg::idx_t      last_reg;
    sspf_pkg::idx_t      idx_reg, idx_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg;
    logic                m_last_reg;

    logic                s_xfer;
    logic                out_load;
    logic                pkt_done;
    logic                op_ok;
    logic [7:0]          sum_in;
    sspf_pkg::idx_t      last_in;
    logic [7:0]          byte_sel;
    logic                last_sel;

    // handshake
    assign out_load = pkt_valid_reg && (!m_valid_reg || m_tready);
    assign last_sel = (idx_reg == last_reg);
    assign pkt_done = out_load && last_sel;
    assign s_tready = aresetn && (!pkt_valid_reg || pkt_done);
    assign s_xfer   = s_tvalid && s_tready;
    assign op_ok    = (s_op != sspf_pkg::OP_CODE_UNDEF);

    // checksum and packet length of the incoming command
    always_comb begin
        sum_in  = s_servo_id ^ sspf_pkg::FLAGS_BYTE ^ sspf_pkg::COUNT_BYTE;
        last_in = sspf_pkg::LAST_TORQUE;
        unique case (s_op)
            sspf_pkg::OP_TORQUE: begin
                sum_in  = sum_in ^ sspf_pkg::ADDR_TORQUE ^ sspf_pkg::LEN_TORQUE ^ s_value[7:0];
                last_in = sspf_pkg::LAST_TORQUE;
            end
            sspf_pkg::OP_GOAL: begin
                sum_in  = sum_in ^ sspf_pkg::ADDR_GOAL ^ sspf_pkg::LEN_GOAL
                        ^ s_value[7:0] ^ s_value[15:8];
                last_in = sspf_pkg::LAST_GOAL;
            end
            sspf_pkg::OP_GOAL_TIME: begin
                sum_in  = sum_in ^ sspf_pkg::ADDR_GOAL ^ sspf_pkg::LEN_TIME
                        ^ s_value[7:0] ^ s_value[15:8]
                        ^ s_move_time[7:0] ^ s_move_time[15:8];
                last_in = sspf_pkg::LAST_TIME;
            end
            default: begin
                sum_in  = 8'h00;
                last_in = sspf_pkg::LAST_TORQUE;
            end
        endcase
    end

    // byte selection for the current index
    always_comb begin
        byte_sel = 8'h00;
        unique case (idx_reg)
            sspf_pkg::IDX_HDR0:  byte_sel = sspf_pkg::HDR0_BYTE;
            sspf_pkg::IDX_HDR1:  byte_sel = sspf_pkg::HDR1_BYTE;
            sspf_pkg::IDX_ID:    byte_sel = id_reg;
            sspf_pkg::IDX_FLAGS: byte_sel = sspf_pkg::FLAGS_BYTE;
            sspf_pkg::IDX_ADDR:  byte_sel = (op_reg == sspf_pkg::OP_TORQUE) ?
                                            sspf_pkg::ADDR_TORQUE : sspf_pkg::ADDR_GOAL;
            sspf_pkg::IDX_LEN: begin
                unique case (op_reg)
                    sspf_pkg::OP_TORQUE:    byte_sel = sspf_pkg::LEN_TORQUE;
                    sspf_pkg::OP_GOAL:      byte_sel = sspf_pkg::LEN_GOAL;
                    sspf_pkg::OP_GOAL_TIME: byte_sel = sspf_pkg::LEN_TIME;
                    default:                byte_sel = 8'h00;
                endcase
            end
            sspf_pkg::IDX_COUNT: byte_sel = sspf_pkg::COUNT_BYTE;
            sspf_pkg::IDX_D0:    byte_sel = value_reg[7:0];
            sspf_pkg::IDX_D1:    byte_sel = (op_reg == sspf_pkg::OP_TORQUE) ?
                                            sum_reg : value_reg[15:8];
            sspf_pkg::IDX_D2:    byte_sel = (op_reg == sspf_pkg::OP_GOAL) ?
                                            sum_reg : time_reg[7:0];
            sspf_pkg::IDX_D3:    byte_sel = time_reg[15:8];
            sspf_pkg::IDX_D4:    byte_sel = sum_reg;
            default:             byte_sel = 8'h00;
        endcase
    end

    // packet control next state
    always_comb begin
        pkt_valid_next = pkt_valid_reg;
        idx_next       = idx_reg;
        if (out_load) begin
            idx_next = idx_reg + sspf_pkg::idx_t'(1);
        end
        if (pkt_done) begin
            pkt_valid_next = 1'b0;
        end
        if (s_xfer) begin
            pkt_valid_next = op_ok;
            idx_next       = sspf_pkg::IDX_HDR0;
        end
    end

    // output valid next state
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= sspf_pkg::IDX_HDR0;
            m_valid_reg   <= 1'b0;
        end else begin
            pkt_valid_reg <= pkt_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // packet payload capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg    <= sspf_pkg::op_t'(s_op);
            id_reg    <= s_servo_id;
            value_reg <= s_value;
            time_reg  <= s_move_time;
            sum_reg   <= sum_in;
            last_reg  <= last_in;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= byte_sel;
            m_last_reg <= last_sel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `SSPF_ASSERT_SAME(a_idx_in_range, aclk, aresetn, pkt_valid_reg, idx_reg <= last_reg,
        "byte index ran past the checksum byte")
    `SSPF_ASSERT_NEXT(a_undef_dropped, aclk, aresetn,
        s_xfer && (s_op == sspf_pkg::OP_CODE_UNDEF), !pkt_valid_reg,
        "undefined command started a packet")
    `SSPF_ASSERT_NEXT(a_last_marked, aclk, aresetn, pkt_done, m_valid_reg && m_last_reg,
        "checksum byte left without last marker")
    `SSPF_ASSERT_SAME(a_idle_ready, aclk, aresetn, !pkt_valid_reg, s_tready,
        "framer idle but not ready for a command")

endmodule

FILE: tb/servo_short_packet_framer_unit_tb.sv
// testbench for servo_short_packet_framer_unit: directed and random commands, with each
// packet byte checked against a packet builder kept in this file
// depends on sspf_pkg and the servo_short_packet_framer_unit rtl
module servo_short_packet_framer_unit_tb;

    // one expected byte of the serial packet
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } pkt_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // op[1:0], servo_id[9:2], value[25:10], move_time[41:26]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // tx_byte[7:0]
    logic        m_tlast;        // last_byte

    pkt_byte_t   packet_bytes_due[$];
    pkt_byte_t   head_byte;
    int          errors = 0;
    int          cmds_sent = 0;
    int          undef_sent = 0;
    int          bytes_seen = 0;
    int          packets_seen = 0;
    int          burst_left = 4;

    // receiver stall pattern state
    int          rx_phase_left = 0;
    logic [1:0]  rx_mode = 2'd0;
    logic [2:0]  rx_tick = 3'd0;

    servo_short_packet_framer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always #2 aclk = ~aclk;

    // run limit
    initial begin
        #2000000;
        $display("FAIL servo_short_packet_framer_unit");
        $finish;
    end

    // build the byte sequence one command should produce
    function automatic void frame_packet(input sspf_pkg::op_t op, input logic [7:0] id,
                                         input logic [15:0] val, input logic [15:0] mt);
        logic [7:0] body[$];
        logic [7:0] sum;
        body.push_back(id);
        body.push_back(sspf_pkg::FLAGS_BYTE);
        case (op)
            sspf_pkg::OP_TORQUE: begin
                body.push_back(sspf_pkg::ADDR_TORQUE);
                body.push_back(sspf_pkg::LEN_TORQUE);
                body.push_back(sspf_pkg::COUNT_BYTE);
                body.push_back(val[7:0]);
            end
            sspf_pkg::OP_GOAL: begin
                body.push_back(sspf_pkg::ADDR_GOAL);
                body.push_back(sspf_pkg::LEN_GOAL);
                body.push_back(sspf_pkg::COUNT_BYTE);
                body.push_back(val[7:0]);
                body.push_back(val[15:8]);
            end
            default: begin
                body.push_back(sspf_pkg::ADDR_GOAL);
                body.push_back(sspf_pkg::LEN_TIME);
                body.push_back(sspf_pkg::COUNT_BYTE);
                body.push_back(val[7:0]);
                body.push_back(val[15:8]);
                body.push_back(mt[7:0]);
                body.push_back(mt[15:8]);
            end
        endcase
        // checksum covers id through the last data byte
        sum = 8'h00;
        foreach (body[i]) sum = sum ^ body[i];
        packet_bytes_due.push_back('{sspf_pkg::HDR0_BYTE, 1'b0});
        packet_bytes_due.push_back('{sspf_pkg::HDR1_BYTE, 1'b0});
        foreach (body[i]) packet_bytes_due.push_back('{body[i], 1'b0});
        packet_bytes_due.push_back('{sum, 1'b1});
    endfunction

    // hold valid low for a number of cycles
    task automatic rest(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // bursts of back-to-back commands separated by random gaps
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 :
                  ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            if (gap > 0) rest(gap);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // one command transfer, then its expected bytes
    task automatic send_command(input logic [1:0] op, input logic [7:0] id,
                                input logic [15:0] val, input logic [15:0] mt);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, mt, val, id, op};
        do @(posedge aclk); while (!s_tready);
        if (op == sspf_pkg::OP_CODE_UNDEF) begin
            undef_sent++;
        end else begin
            frame_packet(sspf_pkg::op_t'(op), id, val, mt);
            cmds_sent++;
        end
        pace_sender();
    endtask

    // stop sending until every pending byte has left
    task automatic drain_packets();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (packet_bytes_due.size() != 0);
    endtask

    // torque mode: low byte passes through unchanged, high byte and move time are dropped
    task automatic test_torque_modes();
        send_command(sspf_pkg::OP_TORQUE, 8'h00, 16'h0000, 16'h0000);
        send_command(sspf_pkg::OP_TORQUE, 8'hFF, 16'hFF01, 16'hFFFF);
        send_command(sspf_pkg::OP_TORQUE, 8'h5A, 16'h8002, 16'h1234);
        send_command(sspf_pkg::OP_TORQUE, 8'hA5, 16'h00FF, 16'h8000);
        send_command(sspf_pkg::OP_TORQUE, 8'h01, 16'h7F07, 16'h0001);
    endtask

    // goal position at the ends of the signed range, move time ignored
    task automatic test_goal_extremes();
        send_command(sspf_pkg::OP_GOAL, 8'h00, 16'h8000, 16'hFFFF);
        send_command(sspf_pkg::OP_GOAL, 8'hFF, 16'h7FFF, 16'h0000);
        send_command(sspf_pkg::OP_GOAL, 8'h3C, 16'h0000, 16'hA5A5);
        send_command(sspf_pkg::OP_GOAL, 8'hC3, 16'hFFFF, 16'h5A5A);
        send_command(sspf_pkg::OP_GOAL, 8'h80, 16'h00FF, 16'h0F0F);
    endtask

    // goal position with move time, including both halves at their extremes
    task automatic test_goal_time_extremes();
        send_command(sspf_pkg::OP_GOAL_TIME, 8'h00, 16'h8000, 16'h0000);
        send_command(sspf_pkg::OP_GOAL_TIME, 8'hFF, 16'h7FFF, 16'hFFFF);
        send_command(sspf_pkg::OP_GOAL_TIME, 8'h11, 16'hFFFF, 16'h8001);
        send_command(sspf_pkg::OP_GOAL_TIME, 8'hEE, 16'h0001, 16'h00FF);
    endtask

    // undefined command code yields no packet, even between valid ones
    task automatic test_undefined_op();
        send_command(sspf_pkg::OP_CODE_UNDEF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_command(sspf_pkg::OP_GOAL, 8'h42, 16'h1234, 16'h0000);
        send_command(sspf_pkg::OP_CODE_UNDEF, 8'h00, 16'h0000, 16'h0000);
        send_command(sspf_pkg::OP_CODE_UNDEF, 8'h7E, 16'h8001, 16'h4321);
        send_command(sspf_pkg::OP_TORQUE, 8'h24, 16'h0002, 16'hFFFF);
    endtask

    // back-to-back burst, then a full drain before new traffic
    task automatic test_drain_pause();
        burst_left = 8;
        for (int i = 0; i < 6; i++)
            send_command(2'(i % 3), 8'(i * 37), 16'($urandom), 16'($urandom));
        drain_packets();
        send_command(sspf_pkg::OP_GOAL_TIME, 8'h99, 16'($urandom), 16'($urandom));
    endtask

    // random commands, mostly well formed with an occasional undefined code
    task automatic test_random_traffic(input int count);
        logic [1:0]  op;
        logic [7:0]  id;
        int          good;
        good = 0;
        while (good < count) begin
            op = ($urandom_range(0, 9) == 0) ? sspf_pkg::OP_CODE_UNDEF :
                                               2'($urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0:       id = 8'h00;
                1:       id = 8'hFF;
                default: id = 8'($urandom);
            endcase
            send_command(op, id, 16'($urandom), 16'($urandom));
            if (op != sspf_pkg::OP_CODE_UNDEF) good++;
            if (good % 100 == 99 && op != sspf_pkg::OP_CODE_UNDEF) drain_packets();
        end
    endtask

    // receiver: phases of always ready, coin flips, a fixed pattern and long stalls
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 3'd1;
        if (rx_phase_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(20, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(0, 1));
            2'd2: m_tready <= 1'(8'b1011_0010 >> rx_tick);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // compare each byte transfer with the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            bytes_seen++;
            if (packet_bytes_due.size() == 0) begin
                $error("unexpected packet byte tx_byte=%02h last_byte=%0b", m_tdata, m_tlast);
                errors++;
            end else begin
                head_byte = packet_bytes_due.pop_front();
                if (m_tdata !== head_byte.tx_byte) begin
                    $error("tx_byte expected %02h actual %02h", head_byte.tx_byte, m_tdata);
                    errors++;
                end
                if (m_tlast !== head_byte.last_byte) begin
                    $error("last_byte expected %0b actual %0b", head_byte.last_byte, m_tlast);
                    errors++;
                end
                if (head_byte.last_byte) packets_seen++;
            end
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_torque_modes();
        test_goal_extremes();
        test_goal_time_extremes();
        test_undefined_op();
        test_drain_pause();
        test_random_traffic(250);

        // let the last packet drain, then watch for stray bytes
        drain_packets();
        repeat (24) @(posedge aclk);
        if (packet_bytes_due.size() != 0) begin
            $error("%0d packet bytes never arrived", packet_bytes_due.size());
            errors++;
        end

        $display("covered %0d commands over all three kinds plus %0d undefined codes,",
                 cmds_sent, undef_sent);
        $display("checked %0d packets of %0d bytes under sender gaps and receiver stalls",
                 packets_seen, bytes_seen);
        if (errors == 0) begin
            $display("PASS servo_short_packet_framer_unit");
        end else begin
            $display("FAIL servo_short_packet_framer_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/sspf_pkg.sv
design/servo_short_packet_framer_unit.sv
tb/servo_short_packet_framer_unit_tb.sv
